### hw/rtl/ggvc_pkg.sv
`default_nettype none

package ggvc_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_PAD   = 12;
    localparam int POS_W        = 16;
    localparam int HD_W         = 15;
    localparam int D_W          = POS_W + 1;
    localparam int SQ_W         = 2 * POS_W;
    localparam int D2_W         = SQ_W + 1;
    localparam int X_W          = 32;
    localparam int Z_W          = 34;
    localparam int ROOT_W       = D2_W + 1;
    localparam int SQRT_STEPS   = (D2_W + 1) / 2;
    localparam int DIST_W       = SQRT_STEPS;
    localparam int ATAN_ENTRIES = 24;
    localparam int ERR_W        = 18;
    localparam int MAG_W        = ERR_W - 1;
    localparam int PROD_W       = POS_W + DIST_W;
    localparam int LIN_W        = 16;
    localparam int TURN_W       = 15;
    localparam int LIN_RAW_W    = PROD_W - FRAC_BITS;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int ZSHIFT       = 30 - FRAC_BITS;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = CFG_IDX_W'(3);

    localparam logic [POS_W-1:0] TARGET_X_RST    = POS_W'(4096);
    localparam logic [POS_W-1:0] TARGET_Y_RST    = POS_W'(4096);
    localparam logic [POS_W-1:0] GAIN_RST        = POS_W'(4096);
    localparam logic [POS_W-1:0] SPEED_LIMIT_RST = POS_W'(12288);

    localparam logic [D2_W-1:0]  NEAR_LIM = D2_W'((64'd1 << (2 * FRAC_BITS)) / 100);
    localparam logic [MAG_W-1:0] TURN_LIM = MAG_W'((64'd1 << FRAC_BITS) / 5);
    localparam logic [MAG_W-1:0] TURN_MAX = MAG_W'((64'd1 << TURN_W) - 1);
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'sd1686629713);
    localparam logic signed [Z_W-1:0] ROUND_Q30   = Z_W'(64'sd1 <<< (ZSHIFT - 1));

    typedef struct packed {
        logic                     vld;
        logic                     far;
        logic signed [X_W-1:0]    x;
        logic signed [X_W-1:0]    y;
        logic signed [Z_W-1:0]    z;
        logic        [D2_W-1:0]   rem;
        logic        [ROOT_W-1:0] root;
        logic signed [HD_W-1:0]   hd;
    } t_core;

    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(64'sd843314856);
            1:  v = Z_W'(64'sd497837829);
            2:  v = Z_W'(64'sd263043836);
            3:  v = Z_W'(64'sd133525158);
            4:  v = Z_W'(64'sd67021686);
            5:  v = Z_W'(64'sd33543515);
            6:  v = Z_W'(64'sd16775850);
            7:  v = Z_W'(64'sd8388437);
            8:  v = Z_W'(64'sd4194282);
            9:  v = Z_W'(64'sd2097149);
            10: v = Z_W'(64'sd1048575);
            11: v = Z_W'(64'sd524287);
            12: v = Z_W'(64'sd262143);
            13: v = Z_W'(64'sd131071);
            14: v = Z_W'(64'sd65535);
            15: v = Z_W'(64'sd32767);
            16: v = Z_W'(64'sd16383);
            17: v = Z_W'(64'sd8191);
            18: v = Z_W'(64'sd4095);
            19: v = Z_W'(64'sd2047);
            20: v = Z_W'(64'sd1023);
            21: v = Z_W'(64'sd511);
            22: v = Z_W'(64'sd255);
            23: v = Z_W'(64'sd127);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ggvc_prep.sv
`default_nettype none

module ggvc_prep (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_vld,
    input  wire logic [ggvc_pkg::POS_W-1:0]          i_pos_x,
    input  wire logic [ggvc_pkg::POS_W-1:0]          i_pos_y,
    input  wire logic signed [ggvc_pkg::HD_W-1:0]    i_heading,
    input  wire logic [ggvc_pkg::POS_W-1:0]          i_target_x,
    input  wire logic [ggvc_pkg::POS_W-1:0]          i_target_y,
    output ggvc_pkg::t_core                          o_item
);

    logic                                   r_a_vld;
    logic signed [ggvc_pkg::D_W-1:0]        r_a_dx;
    logic signed [ggvc_pkg::D_W-1:0]        r_a_dy;
    logic signed [ggvc_pkg::HD_W-1:0]       r_a_hd;

    logic                                   r_b_vld;
    logic [ggvc_pkg::SQ_W-1:0]              r_b_sqx;
    logic [ggvc_pkg::SQ_W-1:0]              r_b_sqy;
    logic signed [ggvc_pkg::X_W-1:0]        r_b_x;
    logic signed [ggvc_pkg::X_W-1:0]        r_b_y;
    logic signed [ggvc_pkg::Z_W-1:0]        r_b_z;
    logic signed [ggvc_pkg::HD_W-1:0]       r_b_hd;

    logic                                   r_c_vld;
    ggvc_pkg::t_core                        r_c_item;

    logic signed [ggvc_pkg::D_W-1:0]        n_a_dx;
    logic signed [ggvc_pkg::D_W-1:0]        n_a_dy;
    logic signed [2*ggvc_pkg::D_W-1:0]      sq_x;
    logic signed [2*ggvc_pkg::D_W-1:0]      sq_y;
    logic signed [ggvc_pkg::X_W-1:0]        xe;
    logic signed [ggvc_pkg::X_W-1:0]        ye;
    logic signed [ggvc_pkg::X_W-1:0]        n_b_x;
    logic signed [ggvc_pkg::X_W-1:0]        n_b_y;
    logic signed [ggvc_pkg::Z_W-1:0]        n_b_z;
    logic [ggvc_pkg::D2_W-1:0]              d2;
    ggvc_pkg::t_core                        n_c_item;

    always_comb begin
        n_a_dx = $signed({1'b0, i_target_x}) - $signed({1'b0, i_pos_x});
        n_a_dy = $signed({1'b0, i_target_y}) - $signed({1'b0, i_pos_y});
    end

    always_comb begin
        sq_x = r_a_dx * r_a_dx;
        sq_y = r_a_dy * r_a_dy;
        xe   = ggvc_pkg::X_W'(r_a_dx) <<< ggvc_pkg::CORDIC_PAD;
        ye   = ggvc_pkg::X_W'(r_a_dy) <<< ggvc_pkg::CORDIC_PAD;
        n_b_x = xe;
        n_b_y = ye;
        n_b_z = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_b_x = ye;
                n_b_y = -xe;
                n_b_z = ggvc_pkg::HALF_PI_Q30;
            end else begin
                n_b_x = -ye;
                n_b_y = xe;
                n_b_z = -ggvc_pkg::HALF_PI_Q30;
            end
        end
    end

    always_comb begin
        d2             = ggvc_pkg::D2_W'(r_b_sqx) + ggvc_pkg::D2_W'(r_b_sqy);
        n_c_item.vld   = r_b_vld;
        n_c_item.far   = d2 > ggvc_pkg::NEAR_LIM;
        n_c_item.x     = r_b_x;
        n_c_item.y     = r_b_y;
        n_c_item.z     = r_b_z;
        n_c_item.rem   = d2;
        n_c_item.root  = '0;
        n_c_item.hd    = r_b_hd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dx   <= n_a_dx;
        r_a_dy   <= n_a_dy;
        r_a_hd   <= i_heading;
        r_b_sqx  <= sq_x[ggvc_pkg::SQ_W-1:0];
        r_b_sqy  <= sq_y[ggvc_pkg::SQ_W-1:0];
        r_b_x    <= n_b_x;
        r_b_y    <= n_b_y;
        r_b_z    <= n_b_z;
        r_b_hd   <= r_a_hd;
        r_c_item <= n_c_item;
    end

    always_comb begin
        o_item     = r_c_item;
        o_item.vld = r_c_vld;
    end

endmodule

`default_nettype wire

### hw/rtl/ggvc_step.sv
`default_nettype none

module ggvc_step #(
    parameter int STEP          = 0,
    parameter int CORDIC_STAGES = ggvc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire ggvc_pkg::t_core i_item,
    output ggvc_pkg::t_core o_item
);

    localparam int SQ_SHIFT = (STEP < ggvc_pkg::SQRT_STEPS) ?
                              (2 * (ggvc_pkg::SQRT_STEPS - 1) - 2 * STEP) : 0;
    localparam logic [ggvc_pkg::ROOT_W-1:0] SQ_BIT = (STEP < ggvc_pkg::SQRT_STEPS) ?
                              (ggvc_pkg::ROOT_W'(1) << SQ_SHIFT) : '0;
    localparam logic signed [ggvc_pkg::Z_W-1:0] ATAN = ggvc_pkg::atan_q30(STEP);

    logic                              r_vld;
    ggvc_pkg::t_core                   r_item;
    ggvc_pkg::t_core                   n_item;
    logic signed [ggvc_pkg::X_W-1:0]   x_in;
    logic signed [ggvc_pkg::X_W-1:0]   y_in;
    logic signed [ggvc_pkg::Z_W-1:0]   z_in;
    logic signed [ggvc_pkg::X_W-1:0]   xs;
    logic signed [ggvc_pkg::X_W-1:0]   ys;
    logic [ggvc_pkg::ROOT_W-1:0]       trial;

    always_comb begin
        n_item = i_item;
        x_in   = i_item.x;
        y_in   = i_item.y;
        z_in   = i_item.z;
        xs     = x_in >>> STEP;
        ys     = y_in >>> STEP;
        trial  = i_item.root + SQ_BIT;
        if (STEP < CORDIC_STAGES) begin
            if (y_in > 0) begin
                n_item.x = x_in + ys;
                n_item.y = y_in - xs;
                n_item.z = z_in + ATAN;
            end else begin
                n_item.x = x_in - ys;
                n_item.y = y_in + xs;
                n_item.z = z_in - ATAN;
            end
        end
        if (STEP < ggvc_pkg::SQRT_STEPS) begin
            if (ggvc_pkg::ROOT_W'(i_item.rem) >= trial) begin
                n_item.rem  = i_item.rem - trial[ggvc_pkg::D2_W-1:0];
                n_item.root = (i_item.root >> 1) + SQ_BIT;
            end else begin
                n_item.root = i_item.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    always_comb begin
        o_item     = r_item;
        o_item.vld = r_vld;
    end

endmodule

`default_nettype wire

### hw/rtl/ggvc_out.sv
`default_nettype none

module ggvc_out (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ggvc_pkg::t_core                   i_item,
    input  wire logic [ggvc_pkg::POS_W-1:0]        i_gain,
    input  wire logic [ggvc_pkg::POS_W-1:0]        i_speed_limit,
    output logic                                   o_done,
    output logic [ggvc_pkg::LIN_W-1:0]             o_linear_speed,
    output logic [ggvc_pkg::TURN_W-1:0]            o_turn_rate
);

    logic                                   r_o1_vld;
    logic                                   r_o1_far;
    logic signed [ggvc_pkg::ERR_W-1:0]      r_o1_err;
    logic [ggvc_pkg::PROD_W-1:0]            r_o1_prod;

    logic                                   r_done;
    logic [ggvc_pkg::LIN_W-1:0]             r_lin;
    logic [ggvc_pkg::TURN_W-1:0]            r_turn;

    logic signed [ggvc_pkg::Z_W-1:0]        zr;
    logic signed [ggvc_pkg::Z_W-1:0]        zs;
    logic signed [ggvc_pkg::ERR_W-1:0]      bearing;
    logic signed [ggvc_pkg::ERR_W-1:0]      n_o1_err;
    logic [ggvc_pkg::PROD_W-1:0]            n_o1_prod;

    logic signed [ggvc_pkg::ERR_W-1:0]      err_abs;
    logic [ggvc_pkg::MAG_W-1:0]             mag;
    logic [ggvc_pkg::MAG_W-1:0]             mag_sat;
    logic [ggvc_pkg::LIN_RAW_W-1:0]         lin_raw;
    logic [ggvc_pkg::LIN_W-1:0]             lin_clamp;
    logic [ggvc_pkg::LIN_W-1:0]             n_lin;
    logic [ggvc_pkg::TURN_W-1:0]            n_turn;

    always_comb begin
        zr        = i_item.z + ggvc_pkg::ROUND_Q30;
        zs        = zr >>> ggvc_pkg::ZSHIFT;
        bearing   = zs[ggvc_pkg::ERR_W-1:0];
        n_o1_err  = bearing - ggvc_pkg::ERR_W'(i_item.hd);
        n_o1_prod = ggvc_pkg::PROD_W'(i_gain) *
                    ggvc_pkg::PROD_W'(i_item.root[ggvc_pkg::DIST_W-1:0]);
    end

    always_comb begin
        err_abs = (r_o1_err < 0) ? -r_o1_err : r_o1_err;
        mag     = err_abs[ggvc_pkg::MAG_W-1:0];
        mag_sat = (mag > ggvc_pkg::TURN_MAX) ? ggvc_pkg::TURN_MAX : mag;
        lin_raw = r_o1_prod[ggvc_pkg::PROD_W-1:ggvc_pkg::FRAC_BITS];
        if (lin_raw > ggvc_pkg::LIN_RAW_W'(i_speed_limit)) begin
            lin_clamp = i_speed_limit;
        end else begin
            lin_clamp = lin_raw[ggvc_pkg::LIN_W-1:0];
        end
        n_lin  = '0;
        n_turn = '0;
        if (r_o1_far) begin
            if (mag > ggvc_pkg::TURN_LIM) begin
                n_turn = mag_sat[ggvc_pkg::TURN_W-1:0];
            end else begin
                n_lin = lin_clamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_o1_vld <= i_item.vld;
            r_done   <= r_o1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o1_far  <= i_item.far;
        r_o1_err  <= n_o1_err;
        r_o1_prod <= n_o1_prod;
        r_lin     <= n_lin;
        r_turn    <= n_turn;
    end

    assign o_done         = r_done;
    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn;

endmodule

`default_nettype wire

### hw/rtl/go_to_goal_velocity_control.sv
// Channel   Handshake                     Payload
// pose in   i_start, accepted if !o_busy  i_pos_x, i_pos_y, i_heading
// command   o_done strobe, one cycle      o_linear_speed, o_turn_rate
// config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One pose per cycle; o_busy stays low.
// Poses pass through ggvc_prep, then the square-root and CORDIC step pipeline that
// retires at most one root bit and one rotation per stage, then ggvc_out.
// Reset is synchronous, active low, clears valid bits and loads config defaults; datapath registers are not reset.
// Results leave on o_done for one cycle; the receiver cannot stall them.
`default_nettype none

module go_to_goal_velocity_control #(
    parameter int CORDIC_STAGES = ggvc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic [ggvc_pkg::POS_W-1:0]            i_pos_x,
    input  wire logic [ggvc_pkg::POS_W-1:0]            i_pos_y,
    input  wire logic signed [ggvc_pkg::HD_W-1:0]      i_heading,
    output logic                                       o_done,
    output logic [ggvc_pkg::LIN_W-1:0]                 o_linear_speed,
    output logic [ggvc_pkg::TURN_W-1:0]                o_turn_rate,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ggvc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ggvc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int NSTEP = (CORDIC_STAGES > ggvc_pkg::SQRT_STEPS) ?
                           CORDIC_STAGES : ggvc_pkg::SQRT_STEPS;

    logic [ggvc_pkg::POS_W-1:0] r_target_x;
    logic [ggvc_pkg::POS_W-1:0] r_target_y;
    logic [ggvc_pkg::POS_W-1:0] r_gain;
    logic [ggvc_pkg::POS_W-1:0] r_speed_limit;

    ggvc_pkg::t_core core_item [0:NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x    <= ggvc_pkg::TARGET_X_RST;
            r_target_y    <= ggvc_pkg::TARGET_Y_RST;
            r_gain        <= ggvc_pkg::GAIN_RST;
            r_speed_limit <= ggvc_pkg::SPEED_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ggvc_pkg::REG_TARGET_X:    r_target_x    <= i_cfg_data;
                ggvc_pkg::REG_TARGET_Y:    r_target_y    <= i_cfg_data;
                ggvc_pkg::REG_GAIN:        r_gain        <= i_cfg_data;
                ggvc_pkg::REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    ggvc_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_start && !o_busy),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_heading  (i_heading),
        .i_target_x (r_target_x),
        .i_target_y (r_target_y),
        .o_item     (core_item[0])
    );

    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        ggvc_step #(
            .STEP          (g),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (core_item[g]),
            .o_item  (core_item[g+1])
        );
    end

    ggvc_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (core_item[NSTEP]),
        .i_gain         (r_gain),
        .i_speed_limit  (r_speed_limit),
        .o_done         (o_done),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate)
    );

endmodule

`default_nettype wire

### dv/tb_go_to_goal_velocity_control.sv
`default_nettype none

module tb_go_to_goal_velocity_control;

    localparam int           STALL_LIMIT  = 1000;
    localparam int           SETTLE_TICKS = 30;
    localparam int           ROT_STAGES   = ggvc_pkg::CORDIC_STAGES_DEF;
    localparam longint       NEAR_SQ      = (64'sd1 <<< (2 * ggvc_pkg::FRAC_BITS)) / 100;
    localparam longint       TURN_MIN     = (64'sd1 <<< ggvc_pkg::FRAC_BITS) / 5;
    localparam longint       TURN_CAP     = (64'sd1 <<< ggvc_pkg::TURN_W) - 1;
    localparam longint       QUARTER_TURN = 64'sd1686629713;
    localparam longint       HALF_LSB_Q30 = 64'sd1 <<< (29 - ggvc_pkg::FRAC_BITS);

    typedef struct packed {
        logic [ggvc_pkg::LIN_W-1:0]  lin;
        logic [ggvc_pkg::TURN_W-1:0] turn;
    } t_vel_cmd;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_start = 1'b0;
    logic [ggvc_pkg::POS_W-1:0]             i_pos_x = '0;
    logic [ggvc_pkg::POS_W-1:0]             i_pos_y = '0;
    logic signed [ggvc_pkg::HD_W-1:0]       i_heading = '0;
    logic                                   i_cfg_valid = 1'b0;
    logic [ggvc_pkg::CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [ggvc_pkg::CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                                   o_busy;
    logic                                   o_done;
    logic [ggvc_pkg::LIN_W-1:0]             o_linear_speed;
    logic [ggvc_pkg::TURN_W-1:0]            o_turn_rate;
    logic                                   o_cfg_ready;

    logic [ggvc_pkg::POS_W-1:0] tgt_x = 16'd4096;
    logic [ggvc_pkg::POS_W-1:0] tgt_y = 16'd4096;
    logic [ggvc_pkg::POS_W-1:0] gain_q = 16'd4096;
    logic [ggvc_pkg::POS_W-1:0] speed_cap = 16'd12288;

    longint   arctan_q30 [ROT_STAGES] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    t_vel_cmd cmd_due [$];
    int       mismatch_count = 0;
    int       stall_cycles = 0;
    bit       gaps_on = 1'b1;

    go_to_goal_velocity_control dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_heading      (i_heading),
        .o_done         (o_done),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint bearing_of(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        int     i;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx <<< ggvc_pkg::CORDIC_PAD;
        y = dy <<< ggvc_pkg::CORDIC_PAD;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (i = 0; i < ROT_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += arctan_q30[i];
            end else begin
                x -= ys;
                y += xs;
                z -= arctan_q30[i];
            end
        end
        return (z + HALF_LSB_Q30) >>> (30 - ggvc_pkg::FRAC_BITS);
    endfunction

    function automatic t_vel_cmd predict_command(logic [ggvc_pkg::POS_W-1:0] px,
                                                 logic [ggvc_pkg::POS_W-1:0] py,
                                                 logic signed [ggvc_pkg::HD_W-1:0] hd);
        longint   dx;
        longint   dy;
        longint   err;
        longint   hd_l;
        longint   d2;
        longint   lin;
        t_vel_cmd c;
        c = '0;
        hd_l = hd;
        dx = longint'(tgt_x) - longint'(px);
        dy = longint'(tgt_y) - longint'(py);
        d2 = dx * dx + dy * dy;
        if (d2 > NEAR_SQ) begin
            err = bearing_of(dx, dy) - hd_l;
            if (err < 0)
                err = -err;
            if (err > TURN_MIN) begin
                c.turn = (err > TURN_CAP) ? ggvc_pkg::TURN_W'(TURN_CAP) :
                                            ggvc_pkg::TURN_W'(err);
            end else begin
                lin = (longint'(gain_q) * root_floor(d2)) >>> ggvc_pkg::FRAC_BITS;
                if (lin > longint'(speed_cap))
                    lin = longint'(speed_cap);
                c.lin = ggvc_pkg::LIN_W'(lin);
            end
        end
        return c;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic send_pose(input logic [ggvc_pkg::POS_W-1:0] px,
                             input logic [ggvc_pkg::POS_W-1:0] py,
                             input logic signed [ggvc_pkg::HD_W-1:0] hd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_start   <= 1'b0;
            i_pos_x   <= ggvc_pkg::POS_W'($urandom);
            i_pos_y   <= ggvc_pkg::POS_W'($urandom);
            i_heading <= ggvc_pkg::HD_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start   <= 1'b1;
        i_pos_x   <= px;
        i_pos_y   <= py;
        i_heading <= hd;
        do @(posedge i_clk); while (o_busy);
        cmd_due.push_back(predict_command(px, py, hd));
    endtask

    task automatic wait_commands_done();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (cmd_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ggvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ggvc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ggvc_pkg::REG_TARGET_X:    tgt_x = data;
            ggvc_pkg::REG_TARGET_Y:    tgt_y = data;
            ggvc_pkg::REG_GAIN:        gain_q = data;
            ggvc_pkg::REG_SPEED_LIMIT: speed_cap = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_vel_cmd want;
        if (i_rst_n && o_done) begin
            if (cmd_due.size() == 0) begin
                report_mismatch($sformatf("unexpected command lin %0d turn %0d",
                                          o_linear_speed, o_turn_rate));
            end else begin
                want = cmd_due.pop_front();
                if (o_linear_speed !== want.lin)
                    report_mismatch($sformatf("linear_speed %0d, want %0d",
                                              o_linear_speed, want.lin));
                if (o_turn_rate !== want.turn)
                    report_mismatch($sformatf("turn_rate %0d, want %0d",
                                              o_turn_rate, want.turn));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_go_to_goal_velocity_control: FAIL");
            $finish;
        end
    end

    task automatic test_pose_extremes();
        send_pose(16'd4096, 16'd4096, 15'sd0);
        send_pose(16'd0, 16'd0, 15'sd3217);
        send_pose(16'd0, 16'd0, -15'sd16384);
        send_pose(16'hFFFF, 16'hFFFF, 15'sd16383);
        send_pose(16'hFFFF, 16'd0, 15'sd0);
        send_pose(16'd0, 16'hFFFF, 15'sd0);
        send_pose(16'd4096, 16'd0, 15'sd6434);
        send_pose(16'd4096, 16'hFFFF, -15'sd6434);
        send_pose(16'd8192, 16'd4096, 15'sd12867);
        send_pose(16'd8192, 16'd4096, -15'sd12868);
        send_pose(16'hAAAA, 16'h5555, 15'sh2AAA);
        send_pose(16'h5555, 16'hAAAA, 15'sh5555);
    endtask

    task automatic test_branch_edges();
        send_pose(16'd3687, 16'd4096, 15'sd0);
        send_pose(16'd3686, 16'd4096, 15'sd0);
        send_pose(16'd4096, 16'd3687, 15'sd6434);
        send_pose(16'd0, 16'd4096, 15'sd819);
        send_pose(16'd0, 16'd4096, 15'sd820);
        send_pose(16'd0, 16'd4096, -15'sd819);
        send_pose(16'd0, 16'd4096, -15'sd820);
    endtask

    task automatic test_reg_extremes();
        wait_commands_done();
        write_reg(ggvc_pkg::REG_GAIN, 16'hFFFF);
        write_reg(ggvc_pkg::REG_SPEED_LIMIT, 16'd100);
        send_pose(16'd0, 16'd0, 15'sd3217);
        wait_commands_done();
        write_reg(ggvc_pkg::REG_SPEED_LIMIT, 16'hFFFF);
        send_pose(16'd0, 16'd0, 15'sd3217);
        wait_commands_done();
        write_reg(ggvc_pkg::REG_GAIN, 16'd0);
        send_pose(16'd0, 16'd0, 15'sd3217);
        wait_commands_done();
        write_reg(ggvc_pkg::REG_GAIN, 16'd4096);
        write_reg(ggvc_pkg::REG_SPEED_LIMIT, 16'd0);
        write_reg(ggvc_pkg::REG_TARGET_X, 16'd0);
        write_reg(ggvc_pkg::REG_TARGET_Y, 16'd0);
        send_pose(16'd0, 16'd0, 15'sd0);
        send_pose(16'hFFFF, 16'hFFFF, -15'sd9651);
        wait_commands_done();
        write_reg(ggvc_pkg::REG_SPEED_LIMIT, 16'hFFFF);
        write_reg(ggvc_pkg::REG_TARGET_X, 16'hFFFF);
        write_reg(ggvc_pkg::REG_TARGET_Y, 16'hFFFF);
        send_pose(16'd0, 16'd0, 15'sd3217);
        wait_commands_done();
        write_reg(ggvc_pkg::CFG_IDX_W'(4), 16'h1234);
        write_reg(ggvc_pkg::CFG_IDX_W'(255), 16'hBEEF);
        send_pose(16'd0, 16'd0, 15'sd3217);
    endtask

    function automatic logic [ggvc_pkg::POS_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'd1;
            1: return 16'd49151;
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            default: return ggvc_pkg::POS_W'($urandom_range(1, 49151));
        endcase
    endfunction

    task automatic test_random_poses();
        int                               phase;
        int                               k;
        int                               r;
        logic [ggvc_pkg::POS_W-1:0]       px;
        logic [ggvc_pkg::POS_W-1:0]       py;
        logic signed [ggvc_pkg::HD_W-1:0] hd;
        for (phase = 0; phase < 8; phase++) begin
            wait_commands_done();
            if (phase == 0) begin
                write_reg(ggvc_pkg::REG_TARGET_X, 16'd1);
                write_reg(ggvc_pkg::REG_TARGET_Y, 16'd1);
                write_reg(ggvc_pkg::REG_GAIN, 16'hFFFF);
                write_reg(ggvc_pkg::REG_SPEED_LIMIT, 16'hFFFF);
            end else if (phase == 1) begin
                write_reg(ggvc_pkg::REG_TARGET_X, 16'd49151);
                write_reg(ggvc_pkg::REG_TARGET_Y, 16'd49151);
                write_reg(ggvc_pkg::REG_GAIN, 16'd1);
                write_reg(ggvc_pkg::REG_SPEED_LIMIT, 16'd0);
            end else begin
                write_reg(ggvc_pkg::REG_TARGET_X, pick_target());
                write_reg(ggvc_pkg::REG_TARGET_Y, pick_target());
                r = $urandom_range(0, 9);
                write_reg(ggvc_pkg::REG_GAIN,
                          (r < 2) ? ((r == 0) ? 16'd0 : 16'hFFFF) :
                          (r < 5) ? ggvc_pkg::POS_W'($urandom) :
                                    ggvc_pkg::POS_W'($urandom_range(0, 8192)));
                r = $urandom_range(0, 9);
                write_reg(ggvc_pkg::REG_SPEED_LIMIT,
                          (r < 2) ? ((r == 0) ? 16'd0 : 16'hFFFF) :
                                    ggvc_pkg::POS_W'($urandom));
                if ($urandom_range(0, 2) == 0)
                    write_reg(ggvc_pkg::CFG_IDX_W'($urandom_range(4, 255)),
                              ggvc_pkg::CFG_DATA_W'($urandom));
            end
            for (k = 0; k < 160; k++) begin
                if (k % 40 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                px = ggvc_pkg::POS_W'($urandom);
                py = ggvc_pkg::POS_W'($urandom);
                hd = ggvc_pkg::HD_W'($urandom);
                if (r < 15) begin
                    px = ggvc_pkg::POS_W'(clip(int'(tgt_x) + $urandom_range(0, 1200) - 600,
                                               0, 65535));
                    py = ggvc_pkg::POS_W'(clip(int'(tgt_y) + $urandom_range(0, 1200) - 600,
                                               0, 65535));
                end
                if (r < 60) begin
                    hd = ggvc_pkg::HD_W'(clip(int'(bearing_of(longint'(tgt_x) - longint'(px),
                                                              longint'(tgt_y) - longint'(py)))
                                              + $urandom_range(0, 2000) - 1000,
                                              -16384, 16383));
                end
                send_pose(px, py, hd);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_pose_extremes();
        test_branch_edges();
        test_reg_extremes();
        test_random_poses();
        wait_commands_done();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_go_to_goal_velocity_control: PASS");
        else
            $display("tb_go_to_goal_velocity_control: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
